// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence required in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lbca_pkg.sv =====
`timescale 1ns / 1ps
package lbca_pkg;

	localparam int KEY_W      = 32;
	localparam int SIZE_W     = 8;
	localparam int CNT_W      = 8;
	localparam int CFG_W      = 8;
	localparam int STATUS_W   = 3;
	localparam int BLK_OUT_W  = 7;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 32;
	localparam int LINK_TAG_W = 2;

	typedef enum logic [LINK_TAG_W-1:0] {
		LINK_TAG_LINK = 2'b00,
		LINK_TAG_END  = 2'b01,
		LINK_TAG_FREE = 2'b10
	} link_tag_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK       = 3'd0,
		STS_NOSPACE  = 3'd1,
		STS_NOTFOUND = 3'd2,
		STS_DIRFULL  = 3'd3,
		STS_ZERO     = 3'd4
	} status_t;

	typedef enum logic {
		MODE_CREATE = 1'b0,
		MODE_DELETE = 1'b1
	} mode_t;

	typedef enum logic [8:0] {
		ST_CLEAR     = 9'b000000001,
		ST_IDLE      = 9'b000000010,
		ST_C_SCAN    = 9'b000000100,
		ST_C_LINK    = 9'b000001000,
		ST_D_FIND    = 9'b000010000,
		ST_D_WALK_RD = 9'b000100000,
		ST_D_WALK_WR = 9'b001000000,
		ST_D_SHIFT   = 9'b010000000,
		ST_DONE      = 9'b100000000
	} state_t;

endpackage

// ===== sv/lbca_link_mem.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbca_link_mem import lbca_pkg::*; #(
	parameter int BLOCKS = 128,
	localparam int BW = $clog2(BLOCKS),
	localparam int LW = BW + LINK_TAG_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr_start,
	output logic          clr_busy,
	input  logic          we,
	input  logic [BW-1:0] waddr,
	input  logic [LW-1:0] wdata,
	input  logic [BW-1:0] raddr,
	output logic [LW-1:0] rdata
);

	logic [LW-1:0] mem [BLOCKS];
	logic [BW-1:0] clr_cnt_q;
	logic          clr_busy_q;
	logic          mem_we;
	logic [BW-1:0] mem_waddr;
	logic [LW-1:0] mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_start) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == BW'(BLOCKS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + BW'(1);
			end
		end
	end

	assign clr_busy  = clr_busy_q;
	assign mem_we    = clr_busy_q || we;
	assign mem_waddr = clr_busy_q ? clr_cnt_q : waddr;
	assign mem_wdata = clr_busy_q ? {LINK_TAG_FREE, BW'(0)} : wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata <= mem[raddr];
	end

	`ASSERT_ALWAYS(a_no_write_in_clear, clk, arst_n, !(clr_busy_q && we), "write during clear pass")
	`ASSERT_ALWAYS(a_clr_cnt_bound, clk, arst_n, int'(clr_cnt_q) < BLOCKS, "clear count overrun")
	`ASSERT_NEXT(a_clr_restart, clk, arst_n, clr_start, clr_busy_q && (clr_cnt_q == '0), "clear not restarted")

endmodule

// ===== sv/linked_block_chain_allocator.sv =====
// Create: the block-table scan reads one entry a cycle from block 0 up to total_blocks,
// linking each free block claimed; a create rejected at input goes straight to the result.
// Delete: the directory is searched for the key, each chain block is read and then freed,
// and every later directory entry moves up one place; a missing key ends the search.
// One item in work at a time; the next item is taken while a result waits in the output.
// Reset and every total_blocks write run a clear pass over all BLOCKS entries of the block
// table, taking no input transfer until it ends; the directory is emptied at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module linked_block_chain_allocator import lbca_pkg::*; #(
	parameter int BLOCKS = 128,
	parameter int MAX_FILES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // file_key, size_blocks
	input  logic                  s_tuser,  // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // status, start_block, end_block, free_count
);

	localparam int BW        = $clog2(BLOCKS);
	localparam int LW        = BW + LINK_TAG_W;
	localparam int SW        = BW + 1;
	localparam int DW        = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
	localparam int CW        = $clog2(MAX_FILES + 1);
	localparam int DEW       = KEY_W + 2 * BW;
	localparam int RESET_EFF = (BLOCKS < 128) ? BLOCKS : 128;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > BLOCKS) begin
			r = CNT_W'(BLOCKS);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	state_t            state_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  free_q;
	logic [CW-1:0]     dcnt_q;
	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] size_q;
	logic [SW-1:0]     scan_q;
	logic [CW-1:0]     didx_q;
	logic [SIZE_W-1:0] got_q;
	logic [BW-1:0]     first_q;
	logic [BW-1:0]     prev_q;
	logic [BW-1:0]     cur_q;
	logic              rd_v_s1;
	logic [BW-1:0]     rd_blk_s1;
	logic [DW-1:0]     rd_dir_s1;
	status_t           sts_q;
	logic [BW-1:0]     res_start_q;
	logic [BW-1:0]     res_end_q;
	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic              clr_busy;
	logic              lm_we;
	logic [BW-1:0]     lm_waddr;
	logic [LW-1:0]     lm_wdata;
	logic [BW-1:0]     lm_raddr;
	logic [LW-1:0]     lm_rdata;
	link_tag_t         lm_tag;

	logic [DEW-1:0]    dir_mem [MAX_FILES];
	logic              dir_we;
	logic [DW-1:0]     dir_waddr;
	logic [DEW-1:0]    dir_wdata;
	logic [DW-1:0]     dir_raddr;
	logic [DEW-1:0]    dir_rdata;
	logic              key_hit;
	logic [BW-1:0]     dir_start;

	logic [SIZE_W-1:0] in_size;
	logic              scan_go;
	logic              dfind_go;
	logic              dshift_go;
	logic              scan_found;
	logic              out_free;

	lbca_link_mem #(
		.BLOCKS(BLOCKS)
	) u_link_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr_start(cfg_we),
		.clr_busy (clr_busy),
		.we       (lm_we),
		.waddr    (lm_waddr),
		.wdata    (lm_wdata),
		.raddr    (lm_raddr),
		.rdata    (lm_rdata)
	);

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		dir_rdata <= dir_mem[dir_raddr];
	end

	assign in_size    = s_tdata[KEY_W +: SIZE_W];
	assign lm_tag     = link_tag_t'(lm_rdata[LW-1 -: LINK_TAG_W]);
	assign key_hit    = dir_rdata[DEW-1 -: KEY_W] == key_q;
	assign dir_start  = dir_rdata[2*BW-1 -: BW];
	assign scan_go    = (state_q == ST_C_SCAN) && (int'(scan_q) < int'(n_q));
	assign dfind_go   = (state_q == ST_D_FIND) && (didx_q < dcnt_q);
	assign dshift_go  = (state_q == ST_D_SHIFT) && (didx_q < dcnt_q);
	assign scan_found = rd_v_s1 && (lm_tag == LINK_TAG_FREE);
	assign out_free   = !m_tvalid_q || m_tready;
	assign s_tready   = state_q == ST_IDLE;
	assign dir_raddr  = didx_q[DW-1:0];
	assign lm_raddr   = (state_q == ST_D_WALK_RD) ? cur_q : scan_q[BW-1:0];

	always_comb begin
		lm_we     = 1'b0;
		lm_waddr  = prev_q;
		lm_wdata  = {LINK_TAG_LINK, rd_blk_s1};
		dir_we    = 1'b0;
		dir_waddr = dcnt_q[DW-1:0];
		dir_wdata = {key_q, first_q, prev_q};
		case (state_q)
			ST_C_SCAN: begin
				lm_we = scan_found && (got_q != '0);
			end
			ST_C_LINK: begin
				lm_we    = got_q != '0;
				lm_wdata = {LINK_TAG_END, BW'(0)};
				dir_we   = got_q != '0;
			end
			ST_D_WALK_WR: begin
				lm_we    = lm_tag != LINK_TAG_FREE;
				lm_waddr = cur_q;
				lm_wdata = {LINK_TAG_FREE, BW'(0)};
			end
			ST_D_SHIFT: begin
				dir_we    = rd_v_s1;
				dir_waddr = rd_dir_s1 - DW'(1);
				dir_wdata = dir_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			n_q         <= CNT_W'(RESET_EFF);
			free_q      <= CNT_W'(RESET_EFF);
			dcnt_q      <= '0;
			key_q       <= '0;
			size_q      <= '0;
			scan_q      <= '0;
			didx_q      <= '0;
			got_q       <= '0;
			first_q     <= '0;
			prev_q      <= '0;
			cur_q       <= '0;
			rd_v_s1     <= 1'b0;
			rd_blk_s1   <= '0;
			rd_dir_s1   <= '0;
			sts_q       <= STS_OK;
			res_start_q <= '0;
			res_end_q   <= '0;
		end else begin
			rd_v_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (!clr_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						key_q       <= s_tdata[KEY_W-1:0];
						size_q      <= in_size;
						scan_q      <= '0;
						didx_q      <= '0;
						got_q       <= '0;
						res_start_q <= '0;
						res_end_q   <= '0;
						if (mode_t'(s_tuser) == MODE_DELETE) begin
							if (dcnt_q == '0) begin
								sts_q   <= STS_NOTFOUND;
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_D_FIND;
							end
						end else if (in_size == '0) begin
							sts_q   <= STS_ZERO;
							state_q <= ST_DONE;
						end else if (in_size > free_q) begin
							sts_q   <= STS_NOSPACE;
							state_q <= ST_DONE;
						end else if (int'(dcnt_q) >= MAX_FILES) begin
							sts_q   <= STS_DIRFULL;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_C_SCAN;
						end
					end
				end
				ST_C_SCAN: begin
					if (scan_go) begin
						scan_q    <= scan_q + SW'(1);
						rd_v_s1   <= 1'b1;
						rd_blk_s1 <= scan_q[BW-1:0];
					end
					if (scan_found) begin
						if (got_q == '0) begin
							first_q <= rd_blk_s1;
						end
						prev_q <= rd_blk_s1;
						got_q  <= got_q + SIZE_W'(1);
						if (got_q + SIZE_W'(1) == size_q) begin
							state_q <= ST_C_LINK;
						end
					end else if (!rd_v_s1 && !scan_go) begin
						state_q <= ST_C_LINK;
					end
				end
				ST_C_LINK: begin
					if (got_q == '0) begin
						sts_q <= STS_NOSPACE;
					end else begin
						sts_q       <= STS_OK;
						dcnt_q      <= dcnt_q + CW'(1);
						free_q      <= free_q - got_q;
						res_start_q <= first_q;
						res_end_q   <= prev_q;
					end
					state_q <= ST_DONE;
				end
				ST_D_FIND: begin
					if (dfind_go) begin
						didx_q    <= didx_q + CW'(1);
						rd_v_s1   <= 1'b1;
						rd_dir_s1 <= didx_q[DW-1:0];
					end
					if (rd_v_s1 && key_hit) begin
						cur_q       <= dir_start;
						res_start_q <= dir_start;
						didx_q      <= CW'(rd_dir_s1) + CW'(1);
						state_q     <= ST_D_WALK_RD;
					end else if (!rd_v_s1 && !dfind_go) begin
						sts_q   <= STS_NOTFOUND;
						state_q <= ST_DONE;
					end
				end
				ST_D_WALK_RD: begin
					state_q <= ST_D_WALK_WR;
				end
				ST_D_WALK_WR: begin
					if (lm_tag == LINK_TAG_FREE) begin
						state_q <= ST_D_SHIFT;
					end else begin
						free_q <= free_q + CNT_W'(1);
						if (lm_tag == LINK_TAG_END) begin
							state_q <= ST_D_SHIFT;
						end else begin
							cur_q   <= lm_rdata[BW-1:0];
							state_q <= ST_D_WALK_RD;
						end
					end
				end
				ST_D_SHIFT: begin
					if (dshift_go) begin
						didx_q    <= didx_q + CW'(1);
						rd_v_s1   <= 1'b1;
						rd_dir_s1 <= didx_q[DW-1:0];
					end else if (!rd_v_s1) begin
						dcnt_q  <= dcnt_q - CW'(1);
						sts_q   <= STS_OK;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				n_q     <= eff_count(cfg_wdata);
				free_q  <= eff_count(cfg_wdata);
				dcnt_q  <= '0;
				state_q <= ST_CLEAR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
			m_tdata_q  <= OUT_DATA_W'({free_q, BLK_OUT_W'(res_end_q),
				BLK_OUT_W'(res_start_q), sts_q});
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_ALWAYS(a_free_bound, clk, arst_n, free_q <= n_q, "free count above disk size")
	`ASSERT_ALWAYS(a_dir_bound, clk, arst_n, int'(dcnt_q) <= MAX_FILES, "directory overrun")
	`ASSERT_ALWAYS(a_scan_short, clk, arst_n, (state_q == ST_C_SCAN) |-> (got_q < size_q), "scan claimed too many blocks")
	`ASSERT_NEXT(a_done_emits, clk, arst_n, (state_q == ST_DONE) && out_free && !cfg_we, m_tvalid_q && (state_q == ST_IDLE), "result not transferred to output")

endmodule
